>>> rtl/multi_motor_pid_position_drive_assert.svh
// assertion macros shared by the multi-motor pid drive modules
// expects i_clk and i_rst_n in the scope of every use
`ifndef MULTI_MOTOR_PID_POSITION_DRIVE_ASSERT_SVH
`define MULTI_MOTOR_PID_POSITION_DRIVE_ASSERT_SVH

// same-cycle implication
`define MMPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mmpd_pkg.sv
// shared types, widths and codes of the multi-motor pid position drive
// no dependencies
package mmpd_pkg;

    localparam int MOTORS_DEF = 6;

    // field and datapath widths
    localparam int MOTOR_W = 3;
    localparam int POS_W   = 24;
    localparam int DT_W    = 10;
    localparam int ERR_W   = 25;
    localparam int DIFF_W  = 26;
    localparam int NUM_W   = 36;
    localparam int PROD_W  = 53;
    localparam int ACC_W   = 64;
    localparam int INT_W   = 32;
    localparam int ISUM_W  = 37;
    localparam int GAIN_W  = 16;
    localparam int ILIM_W  = 24;
    localparam int OLIM_W  = 8;
    localparam int POL_W   = 6;
    localparam int PWM_W   = 9;
    localparam int DIR_W   = 2;
    localparam int DUTY_W  = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 24;

    // shared divider, two quotient bits per cycle
    localparam int DIV_LONG  = 18;
    localparam int DIV_SHORT = 9;
    localparam int DIV_CNT_W = 5;
    localparam int DVS_W     = 10;
    localparam int SHORT_W   = 18;

    // |T| at or above 256 * 256000 always saturates the output
    localparam logic [ACC_W-1:0] SAT_MAG = 64'd65536000;
    localparam int SCALE_SHIFT = 8;
    localparam logic [DVS_W-1:0] SCALE_DIV = 10'd1000;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GAIN_I   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_GAIN_D   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_INT_LIM  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_OUT_LIM  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_POLARITY = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 16'd256;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 16'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 16'd0;
    localparam logic [ILIM_W-1:0] RST_INT_LIM  = 24'd500000;
    localparam logic [OLIM_W-1:0] RST_OUT_LIM  = 8'd255;
    localparam logic [POL_W-1:0]  RST_POLARITY = 6'd8;

    // multiplier operand select
    localparam logic [1:0] MS_DT = 2'd0;
    localparam logic [1:0] MS_P  = 2'd1;
    localparam logic [1:0] MS_D  = 2'd2;
    localparam logic [1:0] MS_I  = 2'd3;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_ADD   = 2'd2;
    localparam logic [1:0] ACC_SCALE = 2'd3;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_COAST = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_REV   = 2'b11;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [ILIM_W-1:0] integral_limit;
        logic [OLIM_W-1:0] output_limit;
        logic [POL_W-1:0]  polarity_mask;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       calc_err;
        logic       prep;
        logic       integ_wr;
        logic       clear_wr;
        logic       div_start;
        logic       div_short;
        logic       deriv_ld;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic [1:0] acc_op;
        logic       mag_ld;
        logic       pwm_ld;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic run;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/mmpd_div.sv
// shared unsigned restoring divider, two quotient bits per cycle
// depends on mmpd_pkg
module mmpd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_short,
    input  logic [mmpd_pkg::NUM_W-1:0] i_dividend,
    input  logic [mmpd_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [mmpd_pkg::NUM_W-1:0] o_quot
);
    import mmpd_pkg::*;

    logic [DVS_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DVS_W:0]   w_t1;
    logic [DVS_W+1:0] w_d1;
    logic             w_q1;
    logic [DVS_W-1:0] w_rem1;
    logic [DVS_W:0]   w_t2;
    logic [DVS_W+1:0] w_d2;
    logic             w_q2;
    logic [DVS_W-1:0] w_rem2;

    // two dependent restoring steps; remainder stays below the divisor
    always_comb begin
        w_t1   = {r_rem, r_quo[NUM_W-1]};
        w_d1   = {1'b0, w_t1} - {2'b00, r_dvs};
        w_q1   = ~w_d1[DVS_W+1];
        w_rem1 = w_q1 ? w_d1[DVS_W-1:0] : w_t1[DVS_W-1:0];
        w_t2   = {w_rem1, r_quo[NUM_W-2]};
        w_d2   = {1'b0, w_t2} - {2'b00, r_dvs};
        w_q2   = ~w_d2[DVS_W+1];
        w_rem2 = w_q2 ? w_d2[DVS_W-1:0] : w_t2[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_short ? DIV_CNT_W'(DIV_SHORT) : DIV_CNT_W'(DIV_LONG);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // short mode expects the dividend aligned to the top bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_quo <= {r_quo[NUM_W-3:0], w_q1, w_q2};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> rtl/mmpd_ctrl.sv
// sequencer of the multi-motor pid drive: steps one tick through the datapath
// depends on mmpd_pkg and the assertion macro header
`include "multi_motor_pid_position_drive_assert.svh"

module mmpd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mmpd_pkg::t_stat i_stat,
    output mmpd_pkg::t_cmd  o_cmd
);
    import mmpd_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_MUL_E = 4'd2;
    localparam logic [3:0] ST_INTEG = 4'd3;
    localparam logic [3:0] ST_DIV_D = 4'd4;
    localparam logic [3:0] ST_MUL_P = 4'd5;
    localparam logic [3:0] ST_MUL_D = 4'd6;
    localparam logic [3:0] ST_ACC_D = 4'd7;
    localparam logic [3:0] ST_SCALE = 4'd8;
    localparam logic [3:0] ST_MUL_I = 4'd9;
    localparam logic [3:0] ST_ACC_I = 4'd10;
    localparam logic [3:0] ST_MAG   = 4'd11;
    localparam logic [3:0] ST_DIV_O = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.calc_err = 1'b1;
                if (i_stat.run) begin
                    n_state = ST_MUL_E;
                end else begin
                    o_cmd.clear_wr = 1'b1;
                    n_state        = ST_DONE;
                end
            end
            ST_MUL_E: begin
                o_cmd.prep    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DT;
                n_state       = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.integ_wr  = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_D;
            end
            ST_DIV_D: begin
                if (i_stat.div_done) begin
                    o_cmd.deriv_ld = 1'b1;
                    n_state        = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_P;
                n_state       = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_D;
                o_cmd.acc_op  = ACC_LOAD;
                n_state       = ST_ACC_D;
            end
            ST_ACC_D: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.acc_op = ACC_SCALE;
                n_state      = ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_I;
                n_state       = ST_ACC_I;
            end
            ST_ACC_I: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag_ld    = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_short = 1'b1;
                n_state         = ST_DIV_O;
            end
            ST_DIV_O: begin
                if (i_stat.div_done) begin
                    o_cmd.pwm_ld = 1'b1;
                    n_state      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    `MMPD_ASSERT_IMP(a_div_done_awaited, i_stat.div_done, (r_state == ST_DIV_D) || (r_state == ST_DIV_O), "divider finished while sequencer not waiting")
    `MMPD_ASSERT_IMP(a_out_load_free, o_cmd.out_ld, i_stat.out_free, "result loaded over an untaken result")
    `MMPD_ASSERT_NXT(a_capture_to_load, o_cmd.capture, r_state == ST_LOAD, "captured tick not followed by load step")
    `MMPD_ASSERT_IMP(a_store_write_run, o_cmd.integ_wr, i_stat.run, "loop state written for a stopped motor")

endmodule

>>> rtl/mmpd_dp.sv
// datapath of the multi-motor pid drive: per-motor state, shared multiplier,
// accumulator, divider and output register; depends on mmpd_pkg, mmpd_div
`include "multi_motor_pid_position_drive_assert.svh"

module mmpd_dp #(
    parameter int MOTORS = mmpd_pkg::MOTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mmpd_pkg::t_cfg                i_cfg,
    input  mmpd_pkg::t_cmd                i_cmd,
    output mmpd_pkg::t_stat               o_stat,
    input  logic [mmpd_pkg::MOTOR_W-1:0]  i_motor,
    input  logic                          i_enable,
    input  logic [mmpd_pkg::POS_W-1:0]    i_target,
    input  logic [mmpd_pkg::POS_W-1:0]    i_position,
    input  logic [mmpd_pkg::DT_W-1:0]     i_dt_ms,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mmpd_pkg::MOTOR_W-1:0]  o_motor_out,
    output logic [mmpd_pkg::PWM_W-1:0]    o_pwm,
    output logic [mmpd_pkg::DIR_W-1:0]    o_direction,
    output logic [mmpd_pkg::DUTY_W-1:0]   o_duty
);
    import mmpd_pkg::*;

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    // captured tick
    logic [MOTOR_W-1:0] r_motor;
    logic               r_enable;
    logic [POS_W-1:0]   r_target;
    logic [POS_W-1:0]   r_position;
    logic [DT_W-1:0]    r_dt;

    // working registers
    logic [ERR_W-1:0]  r_err;
    logic [ERR_W-1:0]  r_last;
    logic [INT_W-1:0]  r_istore_rd;
    logic [NUM_W-1:0]  r_dnum;
    logic [INT_W-1:0]  r_integ;
    logic [NUM_W-1:0]  r_deriv;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_neg;
    logic              r_sat;
    logic [DUTY_W-1:0] r_pmag;
    logic              r_pneg;

    // per-motor loop state
    logic [INT_W-1:0] r_istore [MOTORS];
    logic [ERR_W-1:0] r_lstore [MOTORS];

    // result register
    logic               r_out_valid;
    logic [MOTOR_W-1:0] r_motor_out;
    logic [PWM_W-1:0]   r_pwm;
    logic [DIR_W-1:0]   r_dir;
    logic [DUTY_W-1:0]  r_duty;

    logic [MIDX_W-1:0] w_idx;
    logic              w_in_range;
    logic [DIFF_W-1:0] w_diff;
    logic [NUM_W-1:0]  w_diff_x;
    logic [NUM_W-1:0]  w_dabs;

    logic [GAIN_W-1:0]        w_mul_a;
    logic [NUM_W-1:0]         w_mul_b;
    logic signed [PROD_W-1:0] w_ma;
    logic signed [PROD_W-1:0] w_mb;
    logic signed [PROD_W-1:0] w_prod;

    logic signed [ISUM_W-1:0] w_isum;
    logic signed [ISUM_W-1:0] w_lim;
    logic signed [ISUM_W-1:0] w_lim_neg;
    logic [ISUM_W-1:0]        w_iclamp;
    logic signed [INT_W-1:0]  w_lim32;
    logic                     w_integ_in_lim;

    logic [ACC_W-1:0]  w_prod_x;
    logic [ACC_W-1:0]  w_mag;
    logic [NUM_W-1:0]  w_div_num;
    logic [DVS_W-1:0]  w_div_dvs;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quot;
    logic [DUTY_W-1:0] w_qmag;
    logic [DUTY_W-1:0] w_pmag;
    logic [7:0]        w_pol_x;
    logic              w_rev;

    assign w_idx      = MIDX_W'(r_motor);
    assign w_in_range = (32'(r_motor) < MOTORS);

    // (err - last) * 1000 by shift and subtract
    assign w_diff   = {r_err[ERR_W-1], r_err} - {r_last[ERR_W-1], r_last};
    assign w_diff_x = {{(NUM_W-DIFF_W){w_diff[DIFF_W-1]}}, w_diff};
    assign w_dabs   = r_dnum[NUM_W-1] ? (~r_dnum + NUM_W'(1)) : r_dnum;

    // shared multiplier: unsigned gain or dt times signed operand
    always_comb begin
        case (i_cmd.mul_sel)
            MS_DT: begin
                w_mul_a = {{(GAIN_W-DT_W){1'b0}}, r_dt};
                w_mul_b = {{(NUM_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            MS_P: begin
                w_mul_a = i_cfg.gain_p;
                w_mul_b = {{(NUM_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            MS_D: begin
                w_mul_a = i_cfg.gain_d;
                w_mul_b = r_deriv;
            end
            default: begin
                w_mul_a = i_cfg.gain_i;
                w_mul_b = {{(NUM_W-INT_W){r_integ[INT_W-1]}}, r_integ};
            end
        endcase
    end

    assign w_ma   = {{(PROD_W-GAIN_W){1'b0}}, w_mul_a};
    assign w_mb   = {{(PROD_W-NUM_W){w_mul_b[NUM_W-1]}}, w_mul_b};
    assign w_prod = w_ma * w_mb;

    // integral update with symmetric clamp
    assign w_isum    = $signed({{(ISUM_W-INT_W){r_istore_rd[INT_W-1]}}, r_istore_rd})
                     + $signed(r_prod[ISUM_W-1:0]);
    assign w_lim     = $signed({{(ISUM_W-ILIM_W){1'b0}}, i_cfg.integral_limit});
    assign w_lim_neg = -w_lim;
    assign w_iclamp  = (w_isum > w_lim)     ? w_lim :
                       (w_isum < w_lim_neg) ? w_lim_neg : w_isum;

    assign w_lim32        = $signed({{(INT_W-ILIM_W){1'b0}}, i_cfg.integral_limit});
    assign w_integ_in_lim = ($signed(r_integ) <= w_lim32) && ($signed(r_integ) >= -w_lim32);

    assign w_prod_x = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_mag    = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;

    assign w_div_num = i_cmd.div_short
                     ? {w_mag[SCALE_SHIFT+SHORT_W-1:SCALE_SHIFT], {(NUM_W-SHORT_W){1'b0}}}
                     : w_dabs;
    assign w_div_dvs = i_cmd.div_short ? SCALE_DIV : r_dt;

    mmpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_short    (i_cmd.div_short),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // output magnitude: saturated or quotient, then the output limit
    assign w_qmag = (r_sat || (|w_quot[NUM_W-1:DUTY_W])) ? {DUTY_W{1'b1}} : w_quot[DUTY_W-1:0];
    assign w_pmag = (w_qmag > i_cfg.output_limit) ? i_cfg.output_limit : w_qmag;

    // motors past the mask width are never reversed
    assign w_pol_x = {{(8-POL_W){1'b0}}, i_cfg.polarity_mask};
    assign w_rev   = w_pol_x[r_motor];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_motor    <= i_motor;
            r_enable   <= i_enable;
            r_target   <= i_target;
            r_position <= i_position;
            r_dt       <= (i_dt_ms == '0) ? DT_W'(1) : i_dt_ms;
            r_pmag     <= '0;
            r_pneg     <= 1'b0;
        end
        if (i_cmd.calc_err) begin
            r_err       <= {r_target[POS_W-1], r_target} - {r_position[POS_W-1], r_position};
            r_last      <= w_in_range ? r_lstore[w_idx] : '0;
            r_istore_rd <= w_in_range ? r_istore[w_idx] : '0;
        end
        if (i_cmd.prep) begin
            r_dnum <= (w_diff_x << 10) - (w_diff_x << 4) - (w_diff_x << 3);
        end
        if (i_cmd.integ_wr) begin
            r_integ <= w_iclamp[INT_W-1:0];
        end
        if (i_cmd.deriv_ld) begin
            r_deriv <= r_dnum[NUM_W-1] ? (~w_quot + NUM_W'(1)) : w_quot;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        case (i_cmd.acc_op)
            ACC_LOAD:  r_acc <= w_prod_x;
            ACC_ADD:   r_acc <= r_acc + w_prod_x;
            ACC_SCALE: r_acc <= (r_acc << 10) - (r_acc << 4) - (r_acc << 3);
            default:   r_acc <= r_acc;
        endcase
        if (i_cmd.mag_ld) begin
            r_neg <= r_acc[ACC_W-1];
            r_sat <= (w_mag >= SAT_MAG);
        end
        if (i_cmd.pwm_ld) begin
            r_pmag <= w_pmag;
            r_pneg <= r_neg && (w_pmag != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTORS; m++) begin
                r_istore[m] <= '0;
                r_lstore[m] <= '0;
            end
        end else if (w_in_range) begin
            if (i_cmd.integ_wr) begin
                r_istore[w_idx] <= w_iclamp[INT_W-1:0];
                r_lstore[w_idx] <= r_err;
            end else if (i_cmd.clear_wr && !r_enable) begin
                r_istore[w_idx] <= '0;
                r_lstore[w_idx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_motor_out <= r_motor;
            r_pwm       <= r_pneg ? (~{1'b0, r_pmag} + PWM_W'(1)) : {1'b0, r_pmag};
            r_duty      <= r_pmag;
            if (r_pmag == '0) begin
                r_dir <= DIR_COAST;
            end else if (r_pneg ^ w_rev) begin
                r_dir <= DIR_REV;
            end else begin
                r_dir <= DIR_FWD;
            end
        end
    end

    assign o_stat.run      = r_enable && w_in_range;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_motor_out = r_motor_out;
    assign o_pwm       = r_pwm;
    assign o_direction = r_dir;
    assign o_duty      = r_duty;

    `MMPD_ASSERT_NXT(a_integ_clamped, i_cmd.integ_wr, w_integ_in_lim, "integral outside its limit")
    `MMPD_ASSERT_NXT(a_pwm_limited, i_cmd.pwm_ld, r_pmag <= i_cfg.output_limit, "output magnitude above limit")
    `MMPD_ASSERT_IMP(a_coast_iff_idle, r_out_valid, (r_duty == '0) == (r_dir == DIR_COAST), "direction and duty disagree")

endmodule

>>> rtl/multi_motor_pid_position_drive.sv
// top level of the multi-motor pid position drive: register file and instances
// depends on mmpd_pkg, mmpd_ctrl, mmpd_dp (which holds mmpd_div)

// PID position loop shared over MOTORS motors (default six). Each input
// transfer is one control tick for one motor; each tick gives exactly one
// result transfer, and the next tick can be taken in the cycle in which
// that result first appears. Most of the work of an enabled tick on a
// valid motor is the shared two-bit-per-cycle divider: the derivative
// (error change * 1000 / dt) runs through it in long mode, and the final
// scaling by 1/256000 runs through the same divider in short mode. One
// 17x36 multiplier is used four times in sequence (err*dt, P, D, I terms).
// A disabled tick or a motor index outside the array skips the arithmetic
// and gives a zero result. A result that is not taken holds the sequencer
// in its last step until the output register frees up. One tick is in
// work at a time; the result sits in an output register, so the next tick
// is accepted while the previous result waits to be taken.
// Integral and last error per motor live in flip-flops cleared by reset.
// Registers are to be written through the config channel only while the
// block is idle; the block itself does not enforce this. The channel is
// always ready and indexes past the last register are ignored.
module multi_motor_pid_position_drive #(
    parameter int MOTORS = mmpd_pkg::MOTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mmpd_pkg::MOTOR_W-1:0]  i_motor,
    input  logic                          i_enable,
    input  logic [mmpd_pkg::POS_W-1:0]    i_target,
    input  logic [mmpd_pkg::POS_W-1:0]    i_position,
    input  logic [mmpd_pkg::DT_W-1:0]     i_dt_ms,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mmpd_pkg::MOTOR_W-1:0]  o_motor_out,
    output logic [mmpd_pkg::PWM_W-1:0]    o_pwm,
    output logic [mmpd_pkg::DIR_W-1:0]    o_direction,
    output logic [mmpd_pkg::DUTY_W-1:0]   o_duty,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mmpd_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [mmpd_pkg::CDATA_W-1:0]  i_cfg_data
);
    import mmpd_pkg::*;

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    // config registers, truncated to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.integral_limit <= RST_INT_LIM;
            r_cfg.output_limit   <= RST_OUT_LIM;
            r_cfg.polarity_mask  <= RST_POLARITY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_P:   r_cfg.gain_p         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:   r_cfg.gain_i         <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:   r_cfg.gain_d         <= i_cfg_data[GAIN_W-1:0];
                CFG_INT_LIM:  r_cfg.integral_limit <= i_cfg_data[ILIM_W-1:0];
                CFG_OUT_LIM:  r_cfg.output_limit   <= i_cfg_data[OLIM_W-1:0];
                CFG_POLARITY: r_cfg.polarity_mask  <= i_cfg_data[POL_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer
    mmpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // arithmetic, loop state and result register
    mmpd_dp #(
        .MOTORS (MOTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_motor     (i_motor),
        .i_enable    (i_enable),
        .i_target    (i_target),
        .i_position  (i_position),
        .i_dt_ms     (i_dt_ms),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_motor_out (o_motor_out),
        .o_pwm       (o_pwm),
        .o_direction (o_direction),
        .o_duty      (o_duty)
    );

endmodule
